/* src/dnsnl_pkg.sv */
// Package for the DNS name length scanner.
// Holds the status codes and the scan state and result types.
// No dependencies.
package dnsnl_pkg;

   // Result status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NAME_BORDER = 3'd1;
   localparam logic [2:0] ST_PTR_BORDER  = 3'd2;
   localparam logic [2:0] ST_UNKNOWN     = 3'd3;
   localparam logic [2:0] ST_TOO_LONG    = 3'd4;

   // Label type in the top two bits of a length byte.
   localparam logic [1:0] KIND_LABEL   = 2'b00;
   localparam logic [1:0] KIND_POINTER = 2'b11;

   // Running length, before the terminator, at which a name is too long.
   localparam logic [8:0] MAX_LENGTH = 9'd255;

   // Scan state carried from byte to byte.
   typedef struct packed {
      logic       scan_active;
      logic [8:0] running_length;
      logic [5:0] label_bytes_left;
   } scan_state_type;

   // One result of the scan.
   typedef struct packed {
      logic       valid;
      logic [8:0] encoded_length;
      logic [2:0] scan_status;
   } scan_result_type;

endpackage

/* src/dnsnl_req_if.sv */
// Request channel of the DNS name length scanner: one message byte per request.
// Depends on nothing.
interface dnsnl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       name_start;
   logic       message_last;

   modport source (output valid, output data_byte, output name_start,
                   output message_last, input ready);
   modport sink   (input valid, input data_byte, input name_start,
                   input message_last, output ready);
endinterface

/* src/dnsnl_rsp_if.sv */
// Response channel of the DNS name length scanner: one name length per result.
// Depends on nothing.
interface dnsnl_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] encoded_length;
   logic [2:0] scan_status;

   modport source (output valid, output encoded_length, output scan_status,
                   input ready);
   modport sink   (input valid, input encoded_length, input scan_status,
                   output ready);
endinterface

/* src/dnsnl_step.sv */
// Next-state and result logic for one message byte of the name scan.
// Depends on dnsnl_pkg.
module dnsnl_step (
   input  logic [7:0]               data_byte,
   input  logic                     name_start,
   input  logic                     message_last,
   input  dnsnl_pkg::scan_state_type state_cur,
   output dnsnl_pkg::scan_state_type state_next,
   output dnsnl_pkg::scan_result_type result
);
   import dnsnl_pkg::*;

   logic       active;
   logic [8:0] base_length;
   logic [5:0] base_left;
   logic [1:0] kind;
   logic [8:0] label_length;

   // A start marker restarts the scan from zero on this byte.
   assign active       = name_start | state_cur.scan_active;
   assign base_length  = name_start ? 9'd0 : state_cur.running_length;
   assign base_left    = name_start ? 6'd0 : state_cur.label_bytes_left;
   assign kind         = data_byte[7:6];
   assign label_length = base_length + {1'b0, data_byte} + 9'd1;

   // Classify the byte and decide whether the name ends here.
   always_comb begin
      state_next            = state_cur;
      result.valid          = 1'b0;
      result.encoded_length = 9'd0;
      result.scan_status    = ST_OK;
      if (active) begin
         state_next.scan_active      = 1'b1;
         state_next.running_length   = base_length;
         state_next.label_bytes_left = base_left;
         if (base_left != 6'd0) begin
            // Skip one byte of label content.
            state_next.label_bytes_left = base_left - 6'd1;
            if (message_last) begin
               result.valid       = 1'b1;
               result.scan_status = ST_NAME_BORDER;
            end
         end else if (data_byte == 8'd0) begin
            result.valid          = 1'b1;
            result.encoded_length = base_length + 9'd1;
         end else if (kind == KIND_POINTER) begin
            result.valid = 1'b1;
            if (message_last) begin
               result.scan_status = ST_PTR_BORDER;
            end else begin
               result.encoded_length = base_length + 9'd2;
            end
         end else if (kind != KIND_LABEL) begin
            result.valid       = 1'b1;
            result.scan_status = ST_UNKNOWN;
         end else begin
            // Plain label: count the length byte and its content.
            state_next.running_length   = label_length;
            state_next.label_bytes_left = data_byte[5:0];
            if (label_length >= MAX_LENGTH) begin
               result.valid       = 1'b1;
               result.scan_status = ST_TOO_LONG;
            end else if (message_last) begin
               result.valid       = 1'b1;
               result.scan_status = ST_NAME_BORDER;
            end
         end
         // Every result returns the scanner to idle.
         if (result.valid) begin
            state_next.scan_active      = 1'b0;
            state_next.running_length   = 9'd0;
            state_next.label_bytes_left = 6'd0;
         end
      end
   end

endmodule

/* src/dns_name_length_scanner.sv */
// A request byte is registered in the input register, then scanned into the
// result register when that register is free or drains. Throughput: one byte
// per cycle unless the result side stalls; the scan state update is a single add
// and compare on the registered byte. Reset (synchronous) empties both registers
// and returns the scanner to idle, waiting for a start marker.
// Top level of the DNS name length scanner; depends on dnsnl_pkg, the two
// channel interfaces and dnsnl_step.
module dns_name_length_scanner (
   input  logic     clock,
   input  logic     reset,
   dnsnl_req_if.sink   req_chan,
   dnsnl_rsp_if.source rsp_chan
);
   import dnsnl_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_start_ff;
   logic            in_last_ff;
   scan_state_type  state_ff;
   scan_state_type  state_in;
   scan_result_type step_result;
   logic            out_valid_ff;
   logic [8:0]      out_length_ff;
   logic [2:0]      out_status_ff;
   logic            advance;

   // The registered byte moves on when the result register is free or drains.
   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.data_byte;
         in_start_ff <= req_chan.name_start;
         in_last_ff  <= req_chan.message_last;
      end
   end

   dnsnl_step u_step (
      .data_byte    (in_byte_ff),
      .name_start   (in_start_ff),
      .message_last (in_last_ff),
      .state_cur    (state_ff),
      .state_next   (state_in),
      .result       (step_result)
   );

   // Scan state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && step_result.valid) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance && step_result.valid) begin
         out_length_ff <= step_result.encoded_length;
         out_status_ff <= step_result.scan_status;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.encoded_length = out_length_ff;
   assign rsp_chan.scan_status    = out_status_ff;

endmodule

/* tb/dns_name_length_scanner_test.sv */
// Self-checking testbench for the DNS name length scanner: directed names, long
// names, random message streams and back-pressure, checked against a predictor.
// Depends on dnsnl_pkg, dnsnl_req_if, dnsnl_rsp_if and dns_name_length_scanner.
module dns_name_length_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dnsnl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // One name length result as the scanner reports it.
   typedef struct packed {
      logic [8:0] encoded_length;
      logic [2:0] scan_status;
   } name_result_type;

   logic clock = 1'b0;
   logic reset;

   dnsnl_req_if req ();
   dnsnl_rsp_if rsp ();

   dns_name_length_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   // Predictor state: mirrors the scanner between requests.
   logic       scan_on;
   logic [8:0] name_len;
   logic [5:0] skip_left;

   name_result_type awaited_names[$];
   name_result_type predicted;
   name_result_type seen;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              hold_off_left = 0;
   int              name_bytes = 0;

   always #6 clock = ~clock;

   // Ends a scan in the predictor and builds its result.
   function automatic name_result_type close_scan(input logic [8:0] len,
                                                  input logic [2:0] status);
      scan_on   = 1'b0;
      name_len  = '0;
      skip_left = '0;
      return '{encoded_length: len, scan_status: status};
   endfunction

   // Advances the predicted scan by one message byte; returns 1 when the byte
   // finishes the name, with the expected result in res.
   function automatic bit scan_name_byte(input logic [7:0] b, input logic first,
                                         input logic last,
                                         output name_result_type res);
      logic [1:0] kind;
      res = '0;
      if (first) begin
         scan_on   = 1'b1;
         name_len  = '0;
         skip_left = '0;
      end
      if (!scan_on) return 1'b0;

      // Content byte of a label: only the message end matters.
      if (skip_left != 0) begin
         skip_left = skip_left - 6'd1;
         if (last) begin
            res = close_scan(9'd0, ST_NAME_BORDER);
            return 1'b1;
         end
         return 1'b0;
      end

      if (b == 8'd0) begin
         res = close_scan(name_len + 9'd1, ST_OK);
         return 1'b1;
      end

      kind = b[7:6];
      if (kind == KIND_POINTER) begin
         if (last) res = close_scan(9'd0, ST_PTR_BORDER);
         else res = close_scan(name_len + 9'd2, ST_OK);
         return 1'b1;
      end
      if (kind != KIND_LABEL) begin
         res = close_scan(9'd0, ST_UNKNOWN);
         return 1'b1;
      end

      // Length byte: the too-long check wins over the message end.
      name_len  = name_len + {1'b0, b} + 9'd1;
      skip_left = b[5:0];
      if (name_len >= MAX_LENGTH) begin
         res = close_scan(9'd0, ST_TOO_LONG);
         return 1'b1;
      end
      if (last) begin
         res = close_scan(9'd0, ST_NAME_BORDER);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Predicts on every accepted request and checks every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            if (scan_name_byte(req.data_byte, req.name_start, req.message_last,
                               predicted))
               awaited_names = {awaited_names, predicted};
         end
         if (rsp.valid && rsp.ready) begin
            if (awaited_names.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got length %0d status %0d",
                        $realtime, rsp.encoded_length, rsp.scan_status);
            end else begin
               seen = awaited_names.pop_front();
               if (rsp.encoded_length !== seen.encoded_length) begin
                  mismatch_count++;
                  $display("%0t: encoded_length expected %0d, got %0d",
                           $realtime, seen.encoded_length, rsp.encoded_length);
               end
               if (rsp.scan_status !== seen.scan_status) begin
                  mismatch_count++;
                  $display("%0t: scan_status expected %0d, got %0d",
                           $realtime, seen.scan_status, rsp.scan_status);
               end
            end
         end
      end
   end

   // Result side: a counted hold-off, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp.ready     <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dns_name_length_scanner_test: done, errors");
         $finish;
      end
   end

   // Sends one request; starts and ends at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.data_byte    <= b;
      req.name_start   <= first;
      req.message_last <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Sends a length byte and its label content; last_odds gives a one in N
   // chance of a message end on each content byte, 0 for never.
   task automatic send_label(input logic [5:0] len, input logic first,
                             input logic len_last, input int last_odds);
      logic stray_last;
      send_byte({2'b00, len}, first, len_last);
      name_bytes++;
      for (int k = 0; k < len; k++) begin
         stray_last = (last_odds != 0) && ($urandom_range(last_odds - 1) == 0);
         send_byte(8'($urandom_range(255)), 1'b0, stray_last);
         name_bytes++;
      end
   endtask

   // Stops sending until every expected result is in and the pipe is empty.
   task automatic wait_for_results();
      req.valid <= 1'b0;
      while (awaited_names.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Short directed names: every label type, both error borders and restart.
   task automatic test_directed_names();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // Root name, then bytes that are ignored while idle.
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      // One label whose content looks like a terminator and a pointer.
      send_byte(8'h03, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hC0, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      // Pointers, alone and after a label, and a pointer at the message end.
      send_byte(8'hC0, 1'b1, 1'b0);
      send_byte(8'h01, 1'b1, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hC5, 1'b1, 1'b1);
      // Reserved label types, one of them on the last byte.
      send_byte(8'h40, 1'b1, 1'b0);
      send_byte(8'hBF, 1'b1, 1'b0);
      send_byte(8'h80, 1'b1, 1'b1);
      // Message ends on a length byte and on a content byte.
      send_byte(8'h02, 1'b1, 1'b1);
      send_byte(8'h01, 1'b1, 1'b0);
      send_byte(8'h55, 1'b0, 1'b1);
      // A start marker in the middle of a label restarts the scan.
      send_byte(8'h3F, 1'b1, 1'b0);
      send_byte(8'h12, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
      // A terminator on the last byte is still a good name.
      send_byte(8'h00, 1'b1, 1'b1);
      wait_for_results();
   endtask

   // Names at the length limit: 256 and 255 bytes, and one just too long.
   task automatic test_long_names();
      req_idle_pct  = 8;
      rsp_stall_pct = 8;
      for (int n = 0; n < 2; n++) begin
         send_label(6'd63, 1'b1, 1'b0, 0);
         send_label(6'd63, 1'b0, 1'b0, 0);
         send_label(6'd63, 1'b0, 1'b0, 0);
         send_label(6'd61, 1'b0, 1'b0, 0);
         if (n == 0) send_byte(8'hFF, 1'b0, 1'b0);
         else send_byte(8'h00, 1'b0, 1'b0);
      end
      // The crossing length byte also ends the message; too long wins.
      send_label(6'd63, 1'b1, 1'b0, 0);
      send_label(6'd63, 1'b0, 1'b0, 0);
      send_label(6'd63, 1'b0, 1'b0, 0);
      send_byte(8'h3E, 1'b0, 1'b1);
      wait_for_results();
   endtask

   // One random name, mostly well formed, sometimes broken or abandoned,
   // sometimes preceded by bytes outside any name.
   task automatic send_random_name();
      int         label_count;
      int         shape;
      logic [5:0] len;
      logic       first;
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end
      label_count = $urandom_range(4);
      for (int k = 0; k < label_count; k++) begin
         if ($urandom_range(7) == 0) len = 6'($urandom_range(1, 63));
         else len = 6'($urandom_range(1, 6));
         send_label(len, k == 0, $urandom_range(39) == 0, 40);
      end
      first = (label_count == 0);
      shape = $urandom_range(99);
      if (shape < 45) begin
         send_byte(8'h00, first, $urandom_range(3) == 0);
         name_bytes++;
      end else if (shape < 80) begin
         send_byte(8'hC0 | 8'($urandom_range(63)), first, $urandom_range(3) == 0);
         name_bytes++;
      end else if (shape < 90) begin
         send_byte(8'h40 + 8'($urandom_range(127)), first, $urandom_range(1) == 1);
         name_bytes++;
      end
      // Otherwise the name is left open and the next start marker restarts it.
   endtask

   // Random names under one idling pattern.
   task automatic test_random_names(input int idle_pct, input int stall_pct,
                                    input int byte_count);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      name_bytes    = 0;
      while (name_bytes < byte_count) send_random_name();
      wait_for_results();
   endtask

   // Results are held back for a long stretch while root names keep coming,
   // so the scanner fills up and stalls its requests.
   task automatic test_result_backpressure();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_off_left = 200;
      repeat (30) send_byte(8'h00, 1'b1, 1'b0);
      wait_for_results();
   endtask

   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.data_byte    = '0;
      req.name_start   = 1'b0;
      req.message_last = 1'b0;
      rsp.ready        = 1'b0;
      scan_on          = 1'b0;
      name_len         = '0;
      skip_left        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_names();
      test_long_names();
      test_random_names(0, 0, 290);
      test_random_names(80, 0, 290);
      test_random_names(0, 80, 290);
      test_random_names(8, 8, 290);
      test_result_backpressure();

      while (awaited_names.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("dns_name_length_scanner_test: done, clean");
      end else begin
         $display("dns_name_length_scanner_test: done, errors");
      end
      $finish;
   end

endmodule
